// File: rtl/tlc_pkg.sv
// Shared types and constants for the text command LED controller.
// Holds the frame geometry, character codes, command codes and blink kinds.
// No dependencies.
package tlc_pkg;

  localparam int FrameLen = 9;
  localparam int CountW   = $clog2(FrameLen);

  typedef logic [7:0]        byte_t;
  typedef logic [CountW-1:0] count_t;

  localparam byte_t ChHash  = 8'h23;
  localparam byte_t ChStar  = 8'h2A;
  localparam byte_t ChZero  = 8'h30;
  localparam byte_t ChOne   = 8'h31;
  localparam byte_t ChEight = 8'h38;
  localparam byte_t ChB     = 8'h42;
  localparam byte_t ChF     = 8'h46;
  localparam byte_t ChI     = 8'h49;
  localparam byte_t ChK     = 8'h4B;
  localparam byte_t ChL     = 8'h4C;
  localparam byte_t ChN     = 8'h4E;
  localparam byte_t ChO     = 8'h4F;

  localparam byte_t       LedsAllOn   = 8'hFF;
  localparam byte_t       LedsAllOff  = 8'h00;
  localparam logic [15:0] HalfPerRst  = 16'd500;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_ON_ONE    = 3'd1,
    CMD_ON_ALL    = 3'd2,
    CMD_OFF_ONE   = 3'd3,
    CMD_OFF_ALL   = 3'd4,
    CMD_BLINK_ONE = 3'd5,
    CMD_BLINK_ALL = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_IDLE = 3'b001,
    KIND_ONE  = 3'b010,
    KIND_ALL  = 3'b100
  } kind_e;

  typedef struct packed {
    cmd_e       code;
    logic [2:0] led;
  } cmd_t;

endpackage

// File: rtl/tlc_frame_decode.sv
// Frame decoder: builds the view of the frame that the current byte closes
// and matches it against the fixed command texts. Uses tlc_pkg.
module tlc_frame_decode (
  input  tlc_pkg::byte_t  store_i [tlc_pkg::FrameLen],
  input  tlc_pkg::count_t count_i,
  input  tlc_pkg::byte_t  rx_byte_i,
  output tlc_pkg::cmd_t   cmd_o
);
  import tlc_pkg::*;

  byte_t      at [FrameLen];
  logic       dig_ok_on, dig_ok_off, dig_ok_blink;
  logic [2:0] led_on, led_off, blink_led;

  // Bytes already stored sit below the count, the closing byte at the count,
  // and everything past it reads as zero.
  always_comb begin
    for (int p = 0; p < FrameLen; p++) begin
      if (count_t'(p) < count_i) begin
        at[p] = store_i[p];
      end else if (count_t'(p) == count_i) begin
        at[p] = rx_byte_i;
      end else begin
        at[p] = '0;
      end
    end
  end

  always_comb begin
    dig_ok_on    = (at[3] >= ChOne) && (at[3] <= ChEight);
    dig_ok_off   = (at[4] >= ChOne) && (at[4] <= ChEight);
    dig_ok_blink = (at[6] >= ChOne) && (at[6] <= ChEight);
    led_on       = 3'(at[3] - ChOne);
    led_off      = 3'(at[4] - ChOne);
    blink_led    = 3'(at[6] - ChOne);
  end

  always_comb begin
    cmd_o.code = CMD_NONE;
    cmd_o.led  = '0;
    if (at[0] == ChO && at[1] == ChN) begin
      if (at[2] == ChZero && at[4] == ChHash) begin
        if (dig_ok_on) begin
          cmd_o.code = CMD_ON_ONE;
          cmd_o.led  = led_on;
        end
      end else if (at[2] == ChStar && at[3] == ChHash) begin
        cmd_o.code = CMD_ON_ALL;
      end
    end else if (at[0] == ChO && at[1] == ChF && at[2] == ChF) begin
      if (at[3] == ChZero && at[5] == ChHash) begin
        if (dig_ok_off) begin
          cmd_o.code = CMD_OFF_ONE;
          cmd_o.led  = led_off;
        end
      end else if (at[3] == ChStar && at[4] == ChHash) begin
        cmd_o.code = CMD_OFF_ALL;
      end
    end else if (at[0] == ChB && at[1] == ChL && at[2] == ChI && at[3] == ChN
                 && at[4] == ChK) begin
      if (at[5] == ChZero && at[7] == ChHash) begin
        if (dig_ok_blink) begin
          cmd_o.code = CMD_BLINK_ONE;
          cmd_o.led  = blink_led;
        end
      end else if (at[5] == ChStar && at[6] == ChHash) begin
        cmd_o.code = CMD_BLINK_ALL;
      end
    end
  end

endmodule

// File: rtl/text_command_led_controller_core.sv
// Top level of the text command LED controller: frame collection, LED latch,
// blink timer and the result register. Uses tlc_pkg and tlc_frame_decode.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   input   | in        | in_valid_i/in_ready_o  | mode_i, rx_byte_i
//   result  | out       | out_valid_o/out_ready_i| led_pattern_o, blink_active_o,
//           |           |                        | frame_done_o, command_code_o
//   config  | in        | cfg_we_i (no wait)     | cfg_wdata_i (blink half period)
//
// State and result register update at the edge that accepts a request, so one
// request per cycle is sustained while the result is taken (out_ready_i high).
// The result appears on the next cycle and holds until taken; a new request is
// accepted while the result register is empty or being drained the same cycle.
// Reset clears the frame count, LED latch and blink state and sets the half
// period to 500 ticks; no clearing pass is needed.
module text_command_led_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  led_pattern_o,
  output logic        blink_active_o,
  output logic        frame_done_o,
  output logic [2:0]  command_code_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import tlc_pkg::*;

  byte_t       store_q [FrameLen];
  count_t      count_q, count_d;
  byte_t       latch_q, latch_d;
  kind_e       kind_q, kind_d;
  logic [2:0]  target_q, target_d;
  logic        lit_q, lit_d;
  logic [15:0] tick_q, tick_d;
  logic [15:0] half_q;
  logic        out_valid_q;
  byte_t       led_out_q;
  logic        blink_out_q, done_out_q;
  cmd_e        code_out_q;

  cmd_t        cmd;
  logic        accept;
  logic        store_we;
  logic        done;
  cmd_e        code;
  logic [16:0] tick_next;

  tlc_frame_decode u_decode (
    .store_i   (store_q),
    .count_i   (count_q),
    .rx_byte_i (rx_byte_i),
    .cmd_o     (cmd)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tick_next  = {1'b0, tick_q} + 17'd1;

  always_comb begin
    count_d  = count_q;
    latch_d  = latch_q;
    kind_d   = kind_q;
    target_d = target_q;
    lit_d    = lit_q;
    tick_d   = tick_q;
    store_we = 1'b0;
    done     = 1'b0;
    code     = CMD_NONE;
    if (accept) begin
      if (mode_i) begin
        // A half period of zero also passes this compare, so it toggles
        // on every tick.
        if (kind_q != KIND_IDLE) begin
          if (tick_next >= {1'b0, half_q}) begin
            tick_d = '0;
            lit_d  = !lit_q;
            unique case (kind_q)
              KIND_ONE: begin
                if (lit_d) begin
                  latch_d = latch_q | (8'b1 << target_q);
                end else begin
                  latch_d = latch_q & ~(8'b1 << target_q);
                end
              end
              KIND_ALL: latch_d = lit_d ? LedsAllOn : LedsAllOff;
              default:  latch_d = latch_q;
            endcase
          end else begin
            tick_d = tick_next[15:0];
          end
        end
      end else begin
        kind_d   = KIND_IDLE;
        tick_d   = '0;
        store_we = 1'b1;
        if (rx_byte_i == ChHash || count_q == count_t'(FrameLen - 1)) begin
          count_d = '0;
          done    = 1'b1;
          code    = cmd.code;
          unique case (cmd.code)
            CMD_ON_ONE:  latch_d = latch_q | (8'b1 << cmd.led);
            CMD_ON_ALL:  latch_d = LedsAllOn;
            CMD_OFF_ONE: latch_d = latch_q & ~(8'b1 << cmd.led);
            CMD_OFF_ALL: latch_d = LedsAllOff;
            CMD_BLINK_ONE: begin
              kind_d   = KIND_ONE;
              target_d = cmd.led;
              lit_d    = 1'b1;
              latch_d  = latch_q | (8'b1 << cmd.led);
            end
            CMD_BLINK_ALL: begin
              kind_d   = KIND_ALL;
              target_d = '0;
              lit_d    = 1'b1;
              latch_d  = LedsAllOn;
            end
            default: latch_d = latch_q;
          endcase
        end else begin
          count_d = count_q + count_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      latch_q     <= '0;
      kind_q      <= KIND_IDLE;
      target_q    <= '0;
      lit_q       <= 1'b0;
      tick_q      <= '0;
      half_q      <= HalfPerRst;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      latch_q  <= latch_d;
      kind_q   <= kind_d;
      target_q <= target_d;
      lit_q    <= lit_d;
      tick_q   <= tick_d;
      if (cfg_we_i) begin
        half_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  // Stale bytes from earlier frames are masked by the decoder, so the store
  // needs neither reset nor a clear at frame start.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q] <= rx_byte_i;
    end
    if (accept) begin
      led_out_q   <= latch_d;
      blink_out_q <= (kind_d != KIND_IDLE);
      done_out_q  <= done;
      code_out_q  <= code;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign led_pattern_o  = led_out_q;
  assign blink_active_o = blink_out_q;
  assign frame_done_o   = done_out_q;
  assign command_code_o = code_out_q;

  a_code_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_done_o || command_code_o == CMD_NONE))
    else $error("command code reported without a completed frame");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < count_t'(FrameLen))
    else $error("frame byte count ran past the frame length");

  a_idle_tick_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i && kind_q == KIND_IDLE) |=> $stable(latch_q))
    else $error("tick while not blinking changed the LED latch");

  a_blink_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (command_code_o == CMD_BLINK_ONE || command_code_o == CMD_BLINK_ALL))
    |-> blink_active_o)
    else $error("blink command result without blink active");

endmodule
